[hdl/lrfe_pkg.sv]
// Package with the shared types, codes and helpers of the looping rise/fall envelope.
package lrfe_pkg;

  // Operation codes carried by an input item.
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_ALL_OFF  = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_RISE_STEP     = 2'd0,
    REG_FALL_STEP     = 2'd1,
    REG_RELEASE_COEFF = 2'd2,
    REG_LOOP_ENABLE   = 2'd3
  } reg_idx_t;

  // Envelope stage, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_RISE    = 4'b0010,
    ST_FALL    = 4'b0100,
    ST_RELEASE = 4'b1000
  } stage_t;

  // Stage codes as they appear on the result channel.
  localparam logic [1:0] STAGE_IDLE    = 2'd0;
  localparam logic [1:0] STAGE_RISE    = 2'd1;
  localparam logic [1:0] STAGE_FALL    = 2'd2;
  localparam logic [1:0] STAGE_RELEASE = 2'd3;

  // Fixed register and field widths.
  localparam int STEP_W   = 25;
  localparam int COEFF_W  = 24;
  localparam int CFG_W    = 25;
  localparam int NOTE_W   = 7;
  localparam int HELD_W   = 8;

  // Reset values of the configuration registers.
  localparam logic [STEP_W-1:0]  RISE_STEP_RST     = 25'd73360;
  localparam logic [STEP_W-1:0]  FALL_STEP_RST     = 25'd1489;
  localparam logic [COEFF_W-1:0] RELEASE_COEFF_RST = 24'd16750390;

  // Held note value when no note is held.
  localparam logic [HELD_W-1:0] NO_NOTE = 8'hFF;

  // Configuration as seen by the envelope core.
  typedef struct packed {
    logic [STEP_W-1:0]  rise_step;
    logic [STEP_W-1:0]  fall_step;
    logic [COEFF_W-1:0] release_coeff;
    logic               loop_enable;
  } cfg_t;

  // Map the one-hot stage to its channel code.
  function automatic logic [1:0] stage_code(input stage_t st);
    logic [1:0] code;
    case (st)
      ST_RISE:    code = STAGE_RISE;
      ST_FALL:    code = STAGE_FALL;
      ST_RELEASE: code = STAGE_RELEASE;
      default:    code = STAGE_IDLE;
    endcase
    return code;
  endfunction

endpackage

[hdl/lrfe_if.sv]
// Valid/ready channel interfaces for envelope input and result items.
interface lrfe_in_if
  import lrfe_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [NOTE_W-1:0] note;

  modport source (output valid, output operation, output note, input ready);
  modport sink   (input valid, input operation, input note, output ready);
endinterface

interface lrfe_out_if
  import lrfe_pkg::*;
#(
  parameter int LEVEL_FRAC_BITS = 24
) ();
  logic                     valid;
  logic                     ready;
  logic [LEVEL_FRAC_BITS:0] level;
  logic [1:0]               stage;
  logic signed [HELD_W-1:0] held_note;
  logic                     active;

  modport source (output valid, output level, output stage, output held_note,
                  output active, input ready);
  modport sink   (input valid, input level, input stage, input held_note,
                  input active, output ready);
endinterface

[hdl/lrfe_cfg.sv]
// Configuration register file of the envelope unit.
module lrfe_cfg
  import lrfe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [1:0]       index,
  input  logic [CFG_W-1:0] data,
  output cfg_t             cfg
);

  cfg_t cfg_r;

  // Registers load on a write and return to their defaults on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rise_step     <= RISE_STEP_RST;
      cfg_r.fall_step     <= FALL_STEP_RST;
      cfg_r.release_coeff <= RELEASE_COEFF_RST;
      cfg_r.loop_enable   <= 1'b0;
    end else if (we) begin
      case (reg_idx_t'(index))
        REG_RISE_STEP:     cfg_r.rise_step     <= data[STEP_W-1:0];
        REG_FALL_STEP:     cfg_r.fall_step     <= data[STEP_W-1:0];
        REG_RELEASE_COEFF: cfg_r.release_coeff <= data[COEFF_W-1:0];
        REG_LOOP_ENABLE:   cfg_r.loop_enable   <= data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/lrfe_core.sv]
// Envelope state registers and the single-pass next-state logic for one item.
module lrfe_core
  import lrfe_pkg::*;
#(
  parameter int LEVEL_FRAC_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     take,
  input  logic [1:0]               operation,
  input  logic [NOTE_W-1:0]        note,
  input  cfg_t                     cfg,
  output logic [LEVEL_FRAC_BITS:0] res_level,
  output logic [1:0]               res_stage,
  output logic [HELD_W-1:0]        res_note,
  output logic                     res_active
);

  localparam int LW = LEVEL_FRAC_BITS + 1;
  localparam int SW = ((LW > STEP_W) ? LW : STEP_W) + 1;
  localparam int PW = LW + COEFF_W;
  localparam longint unsigned ONE_VAL   = 64'd1 << LEVEL_FRAC_BITS;
  localparam longint unsigned FLOOR_VAL = (ONE_VAL + 64'd5000) / 64'd10000;
  localparam logic [LW-1:0] ENV_ONE   = LW'(ONE_VAL);
  localparam logic [LW-1:0] ENV_FLOOR = LW'(FLOOR_VAL);

  logic [LW-1:0]     level_r, level_nxt;
  stage_t            stage_r, stage_nxt;
  logic [HELD_W-1:0] note_r, note_nxt;
  logic              key_r, key_nxt;

  logic [SW-1:0] rise_sum;
  logic [SW-1:0] fall_step_x;
  logic [PW-1:0] rel_prod;
  logic [LW-1:0] rel_level;

  // Arithmetic for each stage; only one of them is used per item.
  assign rise_sum    = SW'(level_r) + SW'(cfg.rise_step);
  assign fall_step_x = SW'(cfg.fall_step);
  assign rel_prod    = PW'(level_r) * PW'(cfg.release_coeff);
  assign rel_level   = rel_prod[PW-1:COEFF_W];

  // Next state for the item on the input.
  always_comb begin
    level_nxt = level_r;
    stage_nxt = stage_r;
    note_nxt  = note_r;
    key_nxt   = key_r;
    case (op_t'(operation))
      OP_TICK: begin
        case (stage_r)
          ST_RISE: begin
            if (rise_sum >= SW'(ENV_ONE)) begin
              level_nxt = ENV_ONE;
              stage_nxt = ST_FALL;
            end else begin
              level_nxt = rise_sum[LW-1:0];
            end
          end
          ST_FALL: begin
            if (fall_step_x >= SW'(level_r)) begin
              level_nxt = '0;
              stage_nxt = (cfg.loop_enable && key_r) ? ST_RISE : ST_IDLE;
            end else begin
              level_nxt = level_r - fall_step_x[LW-1:0];
            end
          end
          ST_RELEASE: begin
            if (rel_level < ENV_FLOOR) begin
              level_nxt = '0;
              stage_nxt = ST_IDLE;
            end else begin
              level_nxt = rel_level;
            end
          end
          default: ;
        endcase
        // An idle voice has no level and no note.
        if (stage_nxt == ST_IDLE) begin
          level_nxt = '0;
          note_nxt  = NO_NOTE;
        end
      end
      OP_NOTE_ON: begin
        level_nxt = '0;
        stage_nxt = ST_RISE;
        note_nxt  = {1'b0, note};
        key_nxt   = 1'b1;
      end
      OP_NOTE_OFF: begin
        if (note_r == {1'b0, note}) begin
          key_nxt = 1'b0;
          if (stage_r != ST_IDLE) begin
            stage_nxt = ST_RELEASE;
          end
        end
      end
      default: begin
        level_nxt = '0;
        stage_nxt = ST_IDLE;
        note_nxt  = NO_NOTE;
        key_nxt   = 1'b0;
      end
    endcase
  end

  // Voice state advances once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      stage_r <= ST_IDLE;
      note_r  <= NO_NOTE;
      key_r   <= 1'b0;
    end else if (take) begin
      level_r <= level_nxt;
      stage_r <= stage_nxt;
      note_r  <= note_nxt;
      key_r   <= key_nxt;
    end
  end

  // The result of an item is the state it leaves.
  assign res_level  = level_nxt;
  assign res_stage  = stage_code(stage_nxt);
  assign res_note   = note_nxt;
  assign res_active = (stage_nxt != ST_IDLE);

endmodule

[hdl/lrfe_skid.sv]
// Output register with a skid stage for the result channel.
module lrfe_skid #(
  parameter int DATA_W = 36
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic              o_valid_r;
  logic [DATA_W-1:0] o_data_r;
  logic              s_valid_r;
  logic [DATA_W-1:0] s_data_r;
  logic              pop;

  assign pop        = o_valid_r && out_ready;
  assign push_ready = !s_valid_r;

  // Control: the skid entry fills only when the output register is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
    end else if (!o_valid_r || pop) begin
      o_valid_r <= s_valid_r || push;
      s_valid_r <= 1'b0;
    end else if (push) begin
      s_valid_r <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!o_valid_r || pop) begin
      o_data_r <= s_valid_r ? s_data_r : push_data;
    end else if (push) begin
      s_data_r <= push_data;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

endmodule

[hdl/looping_rise_fall_envelope_unit.sv]
// Top level of the looping rise/fall envelope unit.
// An item's result is registered in the output register, or the skid entry on a stall.
// Throughput: one item per cycle while the skid is free; the state updates in one pass.
// A two-entry output buffer keeps input accepts going while one result is stalled.
// Reset (synchronous, rst_n low): voice idle, level 0, no note, key up, output empty.
// Reset also returns the configuration registers to their default values.
module looping_rise_fall_envelope_unit
  import lrfe_pkg::*;
#(
  parameter int LEVEL_FRAC_BITS = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  lrfe_in_if.sink          in_item,
  lrfe_out_if.source       out_item,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int LW     = LEVEL_FRAC_BITS + 1;
  localparam int DATA_W = LW + 2 + HELD_W + 1;

  cfg_t              cfg;
  logic              take;
  logic              buf_ready;
  logic [LW-1:0]     res_level;
  logic [1:0]        res_stage;
  logic [HELD_W-1:0] res_note;
  logic              res_active;
  logic [DATA_W-1:0] out_data;

  assign in_item.ready = buf_ready;
  assign take          = in_item.valid && buf_ready;

  lrfe_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  lrfe_core #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .operation  (in_item.operation),
    .note       (in_item.note),
    .cfg        (cfg),
    .res_level  (res_level),
    .res_stage  (res_stage),
    .res_note   (res_note),
    .res_active (res_active)
  );

  lrfe_skid #(.DATA_W(DATA_W)) u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (take),
    .push_data  ({res_level, res_stage, res_note, res_active}),
    .push_ready (buf_ready),
    .out_valid  (out_item.valid),
    .out_ready  (out_item.ready),
    .out_data   (out_data)
  );

  // Unpack the buffered result onto the channel.
  assign out_item.level     = out_data[DATA_W-1 -: LW];
  assign out_item.stage     = out_data[HELD_W+2 -: 2];
  assign out_item.held_note = out_data[HELD_W:1];
  assign out_item.active    = out_data[0];

endmodule

[hdl/lrfe_checker.sv]
// Port-level checker for the envelope unit, with its bind statement.
module lrfe_checker
  import lrfe_pkg::*;
#(
  parameter int LEVEL_FRAC_BITS = 24
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [LEVEL_FRAC_BITS:0] level,
  input logic [1:0]               stage,
  input logic [HELD_W-1:0]        held_note,
  input logic                     active
);

  localparam logic [LEVEL_FRAC_BITS:0] ENV_ONE = (LEVEL_FRAC_BITS + 1)'(64'd1 << LEVEL_FRAC_BITS);

  // Active flag follows the stage code.
  a_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (active == (stage != STAGE_IDLE)))
    else $error("active flag disagrees with stage");

  // An idle result carries no level and no note.
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && stage == STAGE_IDLE) |-> (level == '0 && held_note == NO_NOTE))
    else $error("idle result with level or note");

  // Level never exceeds full scale.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (level <= ENV_ONE))
    else $error("level above full scale");

  // No result right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(level) && $stable(stage)
                                   && $stable(held_note)))
    else $error("stalled result changed");

endmodule

bind looping_rise_fall_envelope_unit lrfe_checker #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_item.valid),
  .out_ready (out_item.ready),
  .level     (out_item.level),
  .stage     (out_item.stage),
  .held_note (out_item.held_note),
  .active    (out_item.active)
);
